>>> hw/rtl/wep_pkg.sv
// shared types, sizes and codes of the weighted entry picker
package wep_pkg;

    // table sizing
    localparam int MAX_ENTRIES = 64;
    localparam int WEIGHT_BITS = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_W       = WEIGHT_BITS + IDX_W;

    // fixed port widths
    localparam int IN_W_W   = 32;
    localparam int FRAC_W   = 32;
    localparam int OUT_IDX_W = 6;
    localparam int PROD_W   = 2 * FRAC_W;

    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [IDX_W-1:0]       t_index;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [TOT_W-1:0]       t_total;

    // item modes
    typedef enum logic {
        MODE_ADD  = 1'b0,
        MODE_PICK = 1'b1
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_PICKED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SEL_SUM,
        S_WALK,
        S_FINISH
    } t_state;

endpackage

>>> hw/rtl/weighted_entry_picker.sv
// roulette-wheel weighted entry table with add and pick items
//
// Input channel (i_valid / o_ready) carries i_mode, i_weight, i_rand_fraction.
// Output channel (o_valid / i_ready) carries o_status and o_entry_index.
// Every input transfer yields exactly one output transfer, in order.
// An add writes the weight into the table and bumps the count and running
// total in its accept cycle; its result then passes S_FINISH into the output register.
// A pick scales the fraction by the total with one shared 32x32 multiplier
// in S_MUL_LO and S_MUL_HI, adds the partial products in S_SEL_SUM, then walks the
// stored weights with one adder and compare, one entry per cycle, out of a
// table with one write port and a registered read. A pick that lands on entry k
// walks entries 0 through k before it passes S_FINISH to the output register.
// An empty pick or a full add goes straight from the accept to S_FINISH.
// One item is in work at a time: o_ready is high only while the sequencer
// idles; the result register lets the next item be taken while a result
// still waits. If the receiver stalls with a result still held, a finished
// item waits in the sequencer and o_ready stays low.
// Reset (synchronous, active low) empties the table and clears the total;
// table contents are not cleared, entries past the count are never used.
module weighted_entry_picker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [wep_pkg::IN_W_W-1:0]    i_weight,
    input  logic [wep_pkg::FRAC_W-1:0]    i_rand_fraction,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [wep_pkg::OUT_IDX_W-1:0] o_entry_index
);

    wep_pkg::t_state  r_state, n_state;
    wep_pkg::t_count  r_count, n_count;
    wep_pkg::t_total  r_total, n_total;
    wep_pkg::t_total  r_sel, n_sel;
    wep_pkg::t_total  r_acc, n_acc;
    wep_pkg::t_index  r_walk_idx, n_walk_idx;
    wep_pkg::t_index  rd_addr;
    wep_pkg::t_weight r_rd_data;
    wep_pkg::t_weight r_mem [wep_pkg::MAX_ENTRIES];
    logic [wep_pkg::FRAC_W-1:0]  r_frac, n_frac;
    logic [wep_pkg::FRAC_W-1:0]  r_sel_lo, n_sel_lo;
    logic [wep_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [wep_pkg::PROD_W-1:0]  mul_p;
    logic [wep_pkg::FRAC_W-1:0]  mul_b;
    logic [wep_pkg::PROD_W-1:0]  tot_pad;
    wep_pkg::t_status r_res_status, n_res_status;
    wep_pkg::t_index  r_res_index, n_res_index;
    logic             r_out_valid, n_out_valid;
    wep_pkg::t_status r_out_status, n_out_status;
    wep_pkg::t_index  r_out_index, n_out_index;
    wep_pkg::t_total  acc_sum;
    logic             walk_last;
    logic             in_xfer;
    logic             wr_en;

    assign o_ready       = (r_state == wep_pkg::S_IDLE);
    assign in_xfer       = i_valid && o_ready;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = wep_pkg::OUT_IDX_W'(r_out_index);

    // shared multiplier: fraction times one 32-bit half of the total
    assign tot_pad = wep_pkg::PROD_W'(r_total);
    assign mul_b   = (r_state == wep_pkg::S_MUL_LO) ? tot_pad[wep_pkg::FRAC_W-1:0]
                                                    : tot_pad[wep_pkg::PROD_W-1:wep_pkg::FRAC_W];
    assign mul_p   = wep_pkg::PROD_W'(r_frac) * wep_pkg::PROD_W'(mul_b);

    // walk adder and compare
    assign acc_sum   = r_acc + wep_pkg::TOT_W'(r_rd_data);
    assign walk_last = (r_walk_idx == wep_pkg::IDX_W'(r_count - wep_pkg::CNT_W'(1)));

    // sequencer next state and datapath
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_sel        = r_sel;
        n_acc        = r_acc;
        n_walk_idx   = r_walk_idx;
        n_frac       = r_frac;
        n_sel_lo     = r_sel_lo;
        n_prod       = r_prod;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        rd_addr      = '0;
        wr_en        = 1'b0;
        unique case (r_state)
            wep_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_frac      = i_rand_fraction;
                    n_res_index = '0;
                    n_state     = wep_pkg::S_FINISH;
                    if (i_mode == wep_pkg::MODE_ADD) begin
                        if (r_count == wep_pkg::CNT_W'(wep_pkg::MAX_ENTRIES)) begin
                            n_res_status = wep_pkg::ST_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            n_count      = r_count + wep_pkg::CNT_W'(1);
                            n_total      = r_total
                                         + wep_pkg::TOT_W'(wep_pkg::t_weight'(i_weight));
                            n_res_index  = wep_pkg::IDX_W'(r_count);
                            n_res_status = wep_pkg::ST_ADDED;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = wep_pkg::ST_EMPTY;
                    end else begin
                        n_state = wep_pkg::S_MUL_LO;
                    end
                end
            end
            wep_pkg::S_MUL_LO: begin
                n_prod  = mul_p;
                n_state = wep_pkg::S_MUL_HI;
            end
            wep_pkg::S_MUL_HI: begin
                n_sel_lo = r_prod[wep_pkg::PROD_W-1:wep_pkg::FRAC_W];
                n_prod   = mul_p;
                n_state  = wep_pkg::S_SEL_SUM;
            end
            wep_pkg::S_SEL_SUM: begin
                // selector, fetch of entry 0
                n_sel      = wep_pkg::TOT_W'(r_prod + wep_pkg::PROD_W'(r_sel_lo));
                n_acc      = '0;
                n_walk_idx = '0;
                rd_addr    = '0;
                n_state    = wep_pkg::S_WALK;
            end
            wep_pkg::S_WALK: begin
                if ((r_sel < acc_sum) || walk_last) begin
                    n_res_status = wep_pkg::ST_PICKED;
                    n_res_index  = r_walk_idx;
                    n_state      = wep_pkg::S_FINISH;
                end else begin
                    n_acc      = acc_sum;
                    n_walk_idx = r_walk_idx + wep_pkg::IDX_W'(1);
                    rd_addr    = r_walk_idx + wep_pkg::IDX_W'(1);
                end
            end
            wep_pkg::S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_state      = wep_pkg::S_IDLE;
                end
            end
            default: n_state = wep_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wep_pkg::S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_acc        <= n_acc;
        r_walk_idx   <= n_walk_idx;
        r_frac       <= n_frac;
        r_sel_lo     <= n_sel_lo;
        r_prod       <= n_prod;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
    end

    // weight table, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wep_pkg::IDX_W'(r_count)] <= wep_pkg::t_weight'(i_weight);
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wep_pkg::CNT_W'(wep_pkg::MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_count_only_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> $past(in_xfer && (i_mode == wep_pkg::MODE_ADD)))
        else $error("entry count changed without an add transfer");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wep_pkg::S_WALK) |-> (r_count != '0))
        else $error("walk on an empty table");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == wep_pkg::ST_PICKED))
            |-> (wep_pkg::CNT_W'(r_out_index) < r_count))
        else $error("picked index outside the table");

endmodule

>>> test/weighted_entry_picker_tb.sv
// self-checking testbench of the weighted entry picker with its own table tracker
`timescale 1ns / 100ps

// one expected reply of the block
typedef struct packed {
    wep_pkg::t_status                status;
    logic [wep_pkg::OUT_IDX_W-1:0]   index;
} t_reply;

// mirror of the weight table, predicts and checks replies in order
class entry_table_tracker;
    wep_pkg::t_weight    weights [wep_pkg::MAX_ENTRIES];
    int                  count;
    wep_pkg::t_total     total;
    t_reply              awaited [$];
    int                  n_errors;

    function new();
        count    = 0;
        total    = '0;
        n_errors = 0;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // work out the reply of an accepted input transfer
    function void note_transfer(wep_pkg::t_mode mode, logic [wep_pkg::IN_W_W-1:0] weight,
                                logic [wep_pkg::FRAC_W-1:0] fraction);
        t_reply                                      r;
        logic [wep_pkg::FRAC_W+wep_pkg::TOT_W-1:0]   product;
        wep_pkg::t_total                             selector;
        wep_pkg::t_total                             running;
        int                                          k;

        r.status = wep_pkg::ST_ADDED;
        r.index  = '0;
        if (mode == wep_pkg::MODE_ADD) begin
            if (count == wep_pkg::MAX_ENTRIES) begin
                r.status = wep_pkg::ST_FULL;
            end else begin
                weights[count] = wep_pkg::t_weight'(weight);
                total          = total + wep_pkg::t_weight'(weight);
                r.index        = wep_pkg::OUT_IDX_W'(count);
                count++;
            end
        end else if (count == 0) begin
            r.status = wep_pkg::ST_EMPTY;
        end else begin
            // exact scale of the fraction by the total, floor only
            product  = fraction * total;
            selector = wep_pkg::t_total'(product >> wep_pkg::FRAC_W);
            running  = '0;
            r.status = wep_pkg::ST_PICKED;
            // no hit at all (every weight zero) falls back to the last entry
            r.index  = wep_pkg::OUT_IDX_W'(count - 1);
            for (k = 0; k < count; k++) begin
                running = running + weights[k];
                if (selector < running) begin
                    r.index = wep_pkg::OUT_IDX_W'(k);
                    break;
                end
            end
        end
        awaited = {awaited, r};
    endfunction

    // compare one output transfer with the oldest expected reply
    function void check_reply(logic [1:0] status, logic [wep_pkg::OUT_IDX_W-1:0] index);
        t_reply r;

        if (awaited.size() == 0) begin
            n_errors++;
            $display("%0t unexpected reply: expected none, actual status %0d index %0d",
                     $time, status, index);
            return;
        end
        r = awaited.pop_front();
        if (status !== r.status) begin
            n_errors++;
            $display("%0t status mismatch: expected %0d, actual %0d", $time,
                     r.status, status);
        end
        if (index !== r.index) begin
            n_errors++;
            $display("%0t entry_index mismatch: expected %0d, actual %0d", $time,
                     r.index, index);
        end
    endfunction
endclass

module weighted_entry_picker_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 80;
    localparam int RANDOM_ITEMS = 1800;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    logic                            i_mode;
    logic [wep_pkg::IN_W_W-1:0]      i_weight;
    logic [wep_pkg::FRAC_W-1:0]      i_rand_fraction;
    logic                            o_valid;
    logic                            i_ready;
    logic [1:0]                      o_status;
    logic [wep_pkg::OUT_IDX_W-1:0]   o_entry_index;

    entry_table_tracker     tracker;
    bit                     no_idle;
    int                     stall_cycles;

    weighted_entry_picker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_weight        (i_weight),
        .i_rand_fraction (i_rand_fraction),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // random idle cycle, about 24 in a hundred unless idling is off
    function automatic bit take_break();
        return !no_idle && ($urandom_range(0, 99) < 24);
    endfunction

    // receiver side: ready changes on the falling edge
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= !take_break();
        end
    end

    // output transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_reply(o_status, o_entry_index);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL weighted_entry_picker");
            $finish;
        end
    end

    // one input transfer, with random gaps in front
    task automatic send_item(input wep_pkg::t_mode mode,
                             input logic [wep_pkg::IN_W_W-1:0] weight,
                             input logic [wep_pkg::FRAC_W-1:0] fraction);
        bit accepted;

        accepted = 1'b0;
        @(negedge i_clk);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_weight        <= weight;
        i_rand_fraction <= fraction;
        while (!accepted) begin
            @(posedge i_clk);
            if (o_ready) begin
                accepted = 1'b1;
                tracker.note_transfer(mode, weight, fraction);
            end else begin
                @(negedge i_clk);
            end
        end
    endtask

    // hold the sender until every reply is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [wep_pkg::IN_W_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return wep_pkg::IN_W_W'($urandom_range(1, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [wep_pkg::FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        int n;

        tracker         = new();
        no_idle         = 1'b0;
        stall_cycles    = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_mode          = wep_pkg::MODE_ADD;
        i_weight        = '0;
        i_rand_fraction = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pick from an empty table
        send_item(wep_pkg::MODE_PICK, $urandom, $urandom);
        // lone zero weight entry is always picked
        send_item(wep_pkg::MODE_ADD,  32'h0000_0000, $urandom);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'h0000_0000);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'hFFFF_FFFF);
        // all weights zero falls back to the last entry
        send_item(wep_pkg::MODE_ADD,  32'h0000_0000, $urandom);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'h8000_0000);
        // zero weight entries are skipped
        send_item(wep_pkg::MODE_ADD,  32'hFFFF_FFFF, $urandom);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'h0000_0000);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'hFFFF_FFFF);
        // largest fraction reaches past a max weight entry
        send_item(wep_pkg::MODE_ADD,  32'h0000_0001, $urandom);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'hFFFF_FFFF);
        send_item(wep_pkg::MODE_ADD,  32'h0000_0000, $urandom);
        send_item(wep_pkg::MODE_PICK, $urandom, 32'hFFFF_FFFF);
        // alternating bit patterns
        send_item(wep_pkg::MODE_ADD,  32'hAAAA_AAAA, 32'h5555_5555);
        send_item(wep_pkg::MODE_ADD,  32'h5555_5555, 32'hAAAA_AAAA);
        send_item(wep_pkg::MODE_PICK, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(wep_pkg::MODE_PICK, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(wep_pkg::MODE_PICK, $urandom, $urandom);

        // random part: fill the table gradually, then mostly picks
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 400 && n < 700);
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            if (tracker.count < wep_pkg::MAX_ENTRIES && $urandom_range(0, 99) < 30)
                send_item(wep_pkg::MODE_ADD, pick_weight(), $urandom);
            else if (tracker.count == wep_pkg::MAX_ENTRIES && $urandom_range(0, 99) < 10)
                send_item(wep_pkg::MODE_ADD, $urandom, $urandom);
            else
                send_item(wep_pkg::MODE_PICK, $urandom, pick_fraction());
        end
        no_idle = 1'b0;

        // drain and let any stray reply show up
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("PASS weighted_entry_picker");
        end else begin
            $display("FAIL weighted_entry_picker");
        end
        $finish;
    end

endmodule
